>>> hdl/lpc_pkg.sv
// Shared types, register indexes, color modes and the class palette for the
// lidar point colorizer. No dependencies.
package lpc_pkg;

  localparam logic [1:0] MODE_REAL      = 2'd0;
  localparam logic [1:0] MODE_INTENSITY = 2'd1;
  localparam logic [1:0] MODE_CLASS     = 2'd2;
  localparam logic [1:0] MODE_HEIGHT    = 2'd3;

  localparam logic [2:0] REG_COLOR_MODE      = 3'd0;
  localparam logic [2:0] REG_INTENSITY_MIN   = 3'd1;
  localparam logic [2:0] REG_INTENSITY_RANGE = 3'd2;
  localparam logic [2:0] REG_HEIGHT_MIN      = 3'd3;
  localparam logic [2:0] REG_HEIGHT_RANGE    = 3'd4;

  localparam int QUOT_BITS = 8;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       upper;
    rgb_t       rgb;
  } meta_t;

  // LAS class palette, float entries scaled by 255 and rounded.
  function automatic rgb_t class_color(input logic [7:0] cls);
    rgb_t c;
    case (cls) inside
      8'd0, 8'd1: c = '{blue: 8'd255, green: 8'd255, red: 8'd255};
      8'd2:       c = '{blue: 8'd24,  green: 8'd84,  red: 8'd140};
      8'd3:       c = '{blue: 8'd123, green: 8'd234, red: 8'd178};
      8'd4:       c = '{blue: 8'd41,  green: 8'd209, red: 8'd91};
      8'd5:       c = '{blue: 8'd15,  green: 8'd138, red: 8'd52};
      8'd6:       c = '{blue: 8'd30,  green: 8'd202, red: 8'd210};
      8'd7:       c = '{blue: 8'd15,  green: 8'd21,  red: 8'd199};
      8'd8:       c = '{blue: 8'd232, green: 8'd33,  red: 8'd199};
      8'd9:       c = '{blue: 8'd232, green: 8'd95,  red: 8'd33};
      default:    c = '{blue: 8'd223, green: 8'd232, red: 8'd33};
    endcase
    return c;
  endfunction

endpackage

>>> hdl/lidar_point_colorizer_unit.sv
// Top level of the lidar point colorizer: register file, ramp pipeline with
// a pipelined restoring divider, and output register. Depends on lpc_pkg.
//
//   Channel   Direction  Handshake               Content
//   s_*       in         tvalid/tready           one point word
//   m_*       out        tvalid/tready           one RGB word
//   APB       in/out     psel/penable/pready     five setup registers
//
// One word is accepted per cycle while the output side does not stall, and
// every accepted word gives exactly one result word. A word passes four
// front stages, the eight divider stages, which resolve one quotient bit
// each, and then the output register.
// Reset is synchronous and clears all valid bits and restores the register
// defaults. Each stage holds while the stage after it is full and stalled,
// so bubbles close up and input keeps flowing while a result waits.
module lidar_point_colorizer_unit (
  input  logic        clk,
  input  logic        rst,
  // Fields from bit 0: own_red[7:0], own_green[15:8], own_blue[23:16],
  // intensity[39:24], classification[47:40], height[79:48].
  input  logic [79:0] s_tdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // Fields from bit 0: out_red[7:0], out_green[15:8], out_blue[23:16].
  output logic [23:0] m_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lpc_pkg::*;

  // Setup registers.
  logic [1:0]  color_mode;
  logic [15:0] intensity_min;
  logic [15:0] intensity_range;
  logic [31:0] height_min;
  logic [31:0] height_range;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode      <= MODE_INTENSITY;
      intensity_min   <= 16'd0;
      intensity_range <= 16'hFFFF;
      height_min      <= 32'd0;
      height_range    <= 32'h0001_0000;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[4:2])
        REG_COLOR_MODE:      color_mode      <= pwdata[1:0];
        REG_INTENSITY_MIN:   intensity_min   <= pwdata[15:0];
        REG_INTENSITY_RANGE: intensity_range <= pwdata[15:0];
        REG_HEIGHT_MIN:      height_min      <= pwdata;
        REG_HEIGHT_RANGE:    height_range    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_COLOR_MODE:      prdata = {30'd0, color_mode};
      REG_INTENSITY_MIN:   prdata = {16'd0, intensity_min};
      REG_INTENSITY_RANGE: prdata = {16'd0, intensity_range};
      REG_HEIGHT_MIN:      prdata = height_min;
      REG_HEIGHT_RANGE:    prdata = height_range;
      default:             prdata = 32'd0;
    endcase
  end

  // Input word fields.
  rgb_t        own_rgb;
  logic [15:0] intensity;
  logic [7:0]  classification;
  logic [31:0] height;

  assign own_rgb        = '{blue: s_tdata[23:16], green: s_tdata[15:8], red: s_tdata[7:0]};
  assign intensity      = s_tdata[39:24];
  assign classification = s_tdata[47:40];
  assign height         = s_tdata[79:48];

  // Pipeline registers. Divider index 0 is loaded by the numerator stage;
  // divider stage d turns index d into index d+1.
  logic                v1, v2, v3, ov;
  meta_t               ctl1, ctl2, ctl3;
  logic signed [32:0]  diff1;
  logic [31:0]         den1, den2, den3;
  logic signed [34:0]  n2;
  logic [31:0]         u3;
  logic [QUOT_BITS:0]  dv;
  meta_t               dctl [QUOT_BITS+1];
  logic [40:0]         drem [QUOT_BITS+1];
  logic [7:0]          dq   [QUOT_BITS+1];
  logic [31:0]         dden [QUOT_BITS+1];
  rgb_t                out_rgb;

  // Stage advance chain: a stage may load when it is empty or the next one loads.
  logic               go1, go2, go3, go_out;
  logic [QUOT_BITS:0] go_d;

  always_comb begin
    go_out          = !ov || m_tready;
    go_d[QUOT_BITS] = !dv[QUOT_BITS] || go_out;
    for (int d = QUOT_BITS - 1; d >= 0; d--) begin
      go_d[d] = !dv[d] || go_d[d+1];
    end
    go3 = !v3 || go_d[0];
    go2 = !v2 || go3;
    go1 = !v1 || go2;
  end

  assign s_tready = go1;

  // Stage 1: offset from the ramp start and the ramp length, with a zero
  // length treated as one. Real and class colors are settled here.
  logic signed [32:0] diff_next;
  logic [31:0]        den_next;
  meta_t              ctl_next;

  always_comb begin
    if (color_mode == MODE_HEIGHT) begin
      diff_next = $signed({height[31], height}) - $signed({height_min[31], height_min});
      den_next  = (height_range == 32'd0) ? 32'd1 : height_range;
    end else begin
      diff_next = $signed({17'd0, intensity}) - $signed({17'd0, intensity_min});
      den_next  = {16'd0, (intensity_range == 16'd0) ? 16'd1 : intensity_range};
    end
    ctl_next.mode  = color_mode;
    ctl_next.upper = 1'b0;
    ctl_next.rgb   = (color_mode == MODE_REAL) ? own_rgb : class_color(classification);
  end

  // Stage 2: the height ramp works on twice the offset and picks its segment.
  logic signed [34:0] twice2, den2_s, over2;
  logic               upper_next;

  always_comb begin
    den2_s = $signed({3'd0, den1});
    if (ctl1.mode == MODE_HEIGHT) begin
      twice2 = $signed({diff1[32], diff1, 1'b0});
    end else begin
      twice2 = $signed({{2{diff1[32]}}, diff1});
    end
    over2      = twice2 - den2_s;
    upper_next = (ctl1.mode == MODE_HEIGHT) && !over2[34];
  end

  // Stage 3: clamp the ramp position to 0..length.
  logic [31:0] u_next;

  always_comb begin
    if (n2[34]) begin
      u_next = 32'd0;
    end else if (n2 > $signed({3'd0, den2})) begin
      u_next = den2;
    end else begin
      u_next = n2[31:0];
    end
  end

  // Numerator stage: 510*u + D, which divided by 2*D gives 255*u/D rounded.
  logic [40:0] num_next;
  assign num_next = {u3, 9'd0} - {8'd0, u3, 1'b0} + {9'd0, den3};

  // Divider steps: one quotient bit per stage, highest bit first.
  logic [40:0] trial [QUOT_BITS];
  logic [QUOT_BITS-1:0] take;

  always_comb begin
    for (int d = 0; d < QUOT_BITS; d++) begin
      trial[d] = {8'd0, dden[d], 1'b0} << (QUOT_BITS - 1 - d);
      take[d]  = drem[d] >= trial[d];
    end
  end

  // Output mapping from the ramp value.
  logic [7:0] ramp_c;
  rgb_t       map_rgb;

  assign ramp_c = dq[QUOT_BITS];

  always_comb begin
    map_rgb = dctl[QUOT_BITS].rgb;
    case (dctl[QUOT_BITS].mode)
      MODE_INTENSITY: map_rgb = '{blue: ramp_c, green: 8'd255 - ramp_c, red: 8'd0};
      MODE_HEIGHT: begin
        if (dctl[QUOT_BITS].upper) begin
          map_rgb = '{blue: 8'd0, green: 8'd255 - ramp_c, red: ramp_c};
        end else begin
          map_rgb = '{blue: 8'd255 - ramp_c, green: ramp_c, red: 8'd0};
        end
      end
      default: map_rgb = dctl[QUOT_BITS].rgb;
    endcase
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      dv <= '0;
      ov <= 1'b0;
    end else begin
      if (go1) v1 <= s_tvalid;
      if (go2) v2 <= v1;
      if (go3) v3 <= v2;
      if (go_d[0]) dv[0] <= v3;
      for (int d = 0; d < QUOT_BITS; d++) begin
        if (go_d[d+1]) dv[d+1] <= dv[d];
      end
      if (go_out) ov <= dv[QUOT_BITS];
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (go1 && s_tvalid) begin
      diff1 <= diff_next;
      den1  <= den_next;
      ctl1  <= ctl_next;
    end
    if (go2 && v1) begin
      n2   <= upper_next ? over2 : twice2;
      den2 <= den1;
      ctl2 <= '{mode: ctl1.mode, upper: upper_next, rgb: ctl1.rgb};
    end
    if (go3 && v2) begin
      u3   <= u_next;
      den3 <= den2;
      ctl3 <= ctl2;
    end
    if (go_d[0] && v3) begin
      drem[0] <= num_next;
      dq[0]   <= 8'd0;
      dden[0] <= den3;
      dctl[0] <= ctl3;
    end
    for (int d = 0; d < QUOT_BITS; d++) begin
      if (go_d[d+1] && dv[d]) begin
        drem[d+1] <= take[d] ? drem[d] - trial[d] : drem[d];
        dq[d+1]   <= dq[d] | ({7'd0, take[d]} << (QUOT_BITS - 1 - d));
        dden[d+1] <= dden[d];
        dctl[d+1] <= dctl[d];
      end
    end
    if (go_out && dv[QUOT_BITS]) begin
      out_rgb <= map_rgb;
    end
  end

  assign m_tvalid = ov;
  assign m_tdata  = {out_rgb.blue, out_rgb.green, out_rgb.red};

endmodule

>>> hdl/lpc_checker.sv
// Port-level assertions for the lidar point colorizer and the bind that
// attaches them to lidar_point_colorizer_unit. No package dependency.
module lpc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic [23:0] m_tdata,
  input logic        m_tvalid,
  input logic        m_tready
);

  // A stalled result word stays and keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result word changed or dropped");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result word present right after reset");

  // When the output side can move, the whole pipeline moves and input is ready.
  a_flow: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) |-> s_tready)
    else $error("input stalled although output is free");

endmodule

bind lidar_point_colorizer_unit lpc_checker u_lpc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);
